>>> design/mlae_pkg.sv
// mlae_pkg: shared types for the mips-like alu execute unit
// opcodes, operation kinds, beat payload structs, the decoded stage-one record and the stage-two record
// no dependencies
package mlae_pkg;

  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_ADDU  = 5'd1,
    OP_SUB   = 5'd2,
    OP_AND   = 5'd3,
    OP_OR    = 5'd4,
    OP_XOR   = 5'd5,
    OP_NOR   = 5'd6,
    OP_NAND  = 5'd7,
    OP_SLT   = 5'd8,
    OP_SLL   = 5'd9,
    OP_SRL   = 5'd10,
    OP_SRA   = 5'd11,
    OP_ADDI  = 5'd12,
    OP_ADDIU = 5'd13,
    OP_MEMA  = 5'd14,
    OP_LUI   = 5'd15,
    OP_ANDI  = 5'd16,
    OP_ORI   = 5'd17,
    OP_NORI  = 5'd18,
    OP_SLTI  = 5'd19
  } op_e;

  typedef enum logic [3:0] {
    K_ZERO    = 4'd0,
    K_ADD     = 4'd1,
    K_ADD_OVF = 4'd2,
    K_AND     = 4'd3,
    K_OR      = 4'd4,
    K_XOR     = 4'd5,
    K_NOR     = 4'd6,
    K_NAND    = 4'd7,
    K_SLT     = 4'd8,
    K_SLL     = 4'd9,
    K_SRL     = 4'd10,
    K_SRA     = 4'd11
  } kind_e;

  localparam int unsigned DataW = 32;
  localparam int unsigned ImmW  = 16;
  localparam int unsigned ShW   = 5;

  typedef struct packed {
    logic [4:0]       op;
    logic [DataW-1:0] rs_value;
    logic [DataW-1:0] rt_value;
    logic [ImmW-1:0]  immediate;
  } in_t;

  typedef struct packed {
    logic [DataW-1:0] result;
    logic             overflow;
  } out_t;

  typedef struct packed {
    kind_e            kind;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic [ShW-1:0]   sh;
  } dec_t;

  typedef struct packed {
    kind_e            kind;
    logic [DataW-1:0] sum;
    logic [DataW-1:0] logic_res;
    logic [DataW-1:0] shift_res;
    logic             lt;
    logic             sign_a;
    logic             sign_b;
  } exe_t;

endpackage

>>> design/mips_like_alu_execute_unit.sv
// mips_like_alu_execute_unit: three-stage execute alu, decode / compute / select
// depends on mlae_pkg and mlae_decode
//
// usage:
//   input channel in_valid_i / in_data_i / in_stall_o carries one instruction
//   per beat (opcode, rs, rt, raw immediate); output channel out_valid_o /
//   out_data_o / out_stall_i carries one result beat (value, overflow flag)
//   per input beat, in order
//   an accepted input beat moves through s1_q, s2_q and s3_q to its output beat
//   throughput is one beat per cycle while out_stall_i is low; each stage
//   has its own valid bit and takes a new beat whenever it is empty or its
//   contents move on, so empty stages fill while the output beat waits
//   when out_stall_i holds, the output register keeps its beat and the
//   stages behind it fill; in_stall_o rises only when all three stages hold
//   beats and the output is stalled
//   reset clears the three valid bits; no output beat appears until an
//   input beat has gone through
//   the adder, logic unit and barrel shifter sit in the middle stage and set
//   the cycle time; the overflow check and final select have a stage of their own
module mips_like_alu_execute_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  mlae_pkg::in_t  in_data_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  output mlae_pkg::out_t out_data_o,
  input  logic           out_stall_i
);

  mlae_pkg::dec_t dec;
  mlae_pkg::dec_t s1_q;
  mlae_pkg::exe_t s2_d, s2_q;
  mlae_pkg::out_t s3_d, s3_q;
  logic           v1_q, v2_q, v3_q;
  logic           en1, en2, en3;

  mlae_decode u_decode (
    .in_i  (in_data_i),
    .dec_o (dec)
  );

  // stage advance, back to front
  assign en3 = !v3_q || !out_stall_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_stall_o  = !en1;
  assign out_valid_o = v3_q;
  assign out_data_o  = s3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) s1_q <= dec;
    if (en2 && v1_q)       s2_q <= s2_d;
    if (en3 && v2_q)       s3_q <= s3_d;
  end

  // compute stage
  always_comb begin
    s2_d.kind      = s1_q.kind;
    s2_d.sum       = s1_q.a + s1_q.b;
    s2_d.lt        = $signed(s1_q.a) < $signed(s1_q.b);
    s2_d.sign_a    = s1_q.a[mlae_pkg::DataW-1];
    s2_d.sign_b    = s1_q.b[mlae_pkg::DataW-1];
    s2_d.logic_res = '0;
    s2_d.shift_res = '0;
    unique case (s1_q.kind)
      mlae_pkg::K_AND:  s2_d.logic_res = s1_q.a & s1_q.b;
      mlae_pkg::K_OR:   s2_d.logic_res = s1_q.a | s1_q.b;
      mlae_pkg::K_XOR:  s2_d.logic_res = s1_q.a ^ s1_q.b;
      mlae_pkg::K_NOR:  s2_d.logic_res = ~(s1_q.a | s1_q.b);
      mlae_pkg::K_NAND: s2_d.logic_res = ~(s1_q.a & s1_q.b);
      mlae_pkg::K_SLL:  s2_d.shift_res = s1_q.a << s1_q.sh;
      mlae_pkg::K_SRL:  s2_d.shift_res = s1_q.a >> s1_q.sh;
      mlae_pkg::K_SRA:  s2_d.shift_res = $unsigned($signed(s1_q.a) >>> s1_q.sh);
      default:          s2_d.logic_res = '0;
    endcase
  end

  // select stage
  always_comb begin
    s3_d.overflow = 1'b0;
    unique case (s2_q.kind)
      mlae_pkg::K_ADD:     s3_d.result = s2_q.sum;
      mlae_pkg::K_ADD_OVF: begin
        s3_d.result   = s2_q.sum;
        s3_d.overflow = (s2_q.sign_a == s2_q.sign_b) &&
                        (s2_q.sum[mlae_pkg::DataW-1] != s2_q.sign_a);
      end
      mlae_pkg::K_AND, mlae_pkg::K_OR, mlae_pkg::K_XOR,
      mlae_pkg::K_NOR, mlae_pkg::K_NAND: s3_d.result = s2_q.logic_res;
      mlae_pkg::K_SLL, mlae_pkg::K_SRL,
      mlae_pkg::K_SRA:     s3_d.result = s2_q.shift_res;
      mlae_pkg::K_SLT:     s3_d.result = {{(mlae_pkg::DataW-1){1'b0}}, s2_q.lt};
      default:             s3_d.result = '0;
    endcase
  end

  // input stalls only with every stage full and the output blocked
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && out_stall_i))
    else $error("input stalled with room in the pipe");

  // an accepted beat always lands in stage one
  a_accept_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v1_q)
    else $error("accepted beat lost at stage one");

  // overflow only from the checked add kind
  a_ovf_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && en3 && (s2_q.kind != mlae_pkg::K_ADD_OVF)) |=> !s3_q.overflow)
    else $error("overflow flagged for an unchecked operation");

  // a held middle stage keeps its beat while the output is blocked
  a_mid_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !en3) |=> (v2_q && $stable(s2_q)))
    else $error("middle stage changed while blocked");

endmodule

>>> design/mlae_decode.sv
// mlae_decode: maps an opcode beat onto an operation kind and two operands
// immediate extension, subtract negation and lui placement happen here
// depends on mlae_pkg
module mlae_decode (
  input  mlae_pkg::in_t  in_i,
  output mlae_pkg::dec_t dec_o
);

  logic [mlae_pkg::DataW-1:0] imm_sext;
  logic [mlae_pkg::DataW-1:0] imm_zext;

  assign imm_sext = {{(mlae_pkg::DataW - mlae_pkg::ImmW){in_i.immediate[mlae_pkg::ImmW-1]}},
                     in_i.immediate};
  assign imm_zext = {{(mlae_pkg::DataW - mlae_pkg::ImmW){1'b0}}, in_i.immediate};

  always_comb begin
    dec_o.kind = mlae_pkg::K_ZERO;
    dec_o.a    = in_i.rs_value;
    dec_o.b    = in_i.rt_value;
    dec_o.sh   = in_i.immediate[mlae_pkg::ShW-1:0];
    unique case (in_i.op)
      mlae_pkg::OP_ADD:   dec_o.kind = mlae_pkg::K_ADD_OVF;
      mlae_pkg::OP_ADDU:  dec_o.kind = mlae_pkg::K_ADD;
      mlae_pkg::OP_SUB: begin
        dec_o.kind = mlae_pkg::K_ADD_OVF;
        dec_o.b    = ~in_i.rt_value + 32'd1;
      end
      mlae_pkg::OP_AND:   dec_o.kind = mlae_pkg::K_AND;
      mlae_pkg::OP_OR:    dec_o.kind = mlae_pkg::K_OR;
      mlae_pkg::OP_XOR:   dec_o.kind = mlae_pkg::K_XOR;
      mlae_pkg::OP_NOR:   dec_o.kind = mlae_pkg::K_NOR;
      mlae_pkg::OP_NAND:  dec_o.kind = mlae_pkg::K_NAND;
      mlae_pkg::OP_SLT:   dec_o.kind = mlae_pkg::K_SLT;
      mlae_pkg::OP_SLL: begin
        dec_o.kind = mlae_pkg::K_SLL;
        dec_o.a    = in_i.rt_value;
      end
      mlae_pkg::OP_SRL: begin
        dec_o.kind = mlae_pkg::K_SRL;
        dec_o.a    = in_i.rt_value;
      end
      mlae_pkg::OP_SRA: begin
        dec_o.kind = mlae_pkg::K_SRA;
        dec_o.a    = in_i.rt_value;
      end
      mlae_pkg::OP_ADDI, mlae_pkg::OP_MEMA: begin
        dec_o.kind = mlae_pkg::K_ADD_OVF;
        dec_o.b    = imm_sext;
      end
      mlae_pkg::OP_ADDIU: begin
        dec_o.kind = mlae_pkg::K_ADD;
        dec_o.b    = imm_sext;
      end
      mlae_pkg::OP_LUI: begin
        dec_o.kind = mlae_pkg::K_ADD;
        dec_o.a    = '0;
        dec_o.b    = {in_i.immediate, {(mlae_pkg::DataW - mlae_pkg::ImmW){1'b0}}};
      end
      mlae_pkg::OP_ANDI: begin
        dec_o.kind = mlae_pkg::K_AND;
        dec_o.b    = imm_zext;
      end
      mlae_pkg::OP_ORI: begin
        dec_o.kind = mlae_pkg::K_OR;
        dec_o.b    = imm_zext;
      end
      mlae_pkg::OP_NORI: begin
        dec_o.kind = mlae_pkg::K_NOR;
        dec_o.b    = imm_zext;
      end
      mlae_pkg::OP_SLTI: begin
        dec_o.kind = mlae_pkg::K_SLT;
        dec_o.b    = imm_sext;
      end
      default:            dec_o.kind = mlae_pkg::K_ZERO;
    endcase
  end

endmodule

>>> verif/mips_like_alu_execute_unit_tb.sv
// mips_like_alu_execute_unit_tb: self-checking bench for the execute alu, with random idle and stall
// a clocked driver feeds beats from a queue and a clocked monitor checks results against a predictor
// depends on mlae_pkg and the mips_like_alu_execute_unit rtl
module mips_like_alu_execute_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HalfPeriod = 10;
  localparam int unsigned RandBeats = 1100;
  localparam int unsigned QuietTail = 150;
  localparam int unsigned MaxShown = 10;
  localparam logic [4:0] OpNone = 5'd20;
  localparam logic [4:0] OpTop = 5'd31;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  mlae_pkg::in_t in_data_i = '0;
  logic in_stall_o;
  logic out_valid_o;
  mlae_pkg::out_t out_data_o;
  logic out_stall_i = 1'b0;

  mlae_pkg::in_t pending_beats[$];
  mlae_pkg::out_t expected_results[$];
  int unsigned beats_sent = 0;
  int unsigned send_gap = 0;
  int unsigned stall_gap = 0;
  int unsigned mismatch_count = 0;

  mips_like_alu_execute_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_stall_i(out_stall_i)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  function automatic mlae_pkg::out_t add_with_overflow(logic [31:0] a, logic [31:0] b);
    mlae_pkg::out_t r;
    r.result = a + b;
    r.overflow = (a[31] == b[31]) && (r.result[31] != a[31]);
    return r;
  endfunction

  function automatic logic [31:0] signed_less(logic [31:0] a, logic [31:0] b);
    return {31'b0, $signed(a) < $signed(b)};
  endfunction

  function automatic mlae_pkg::out_t alu_predict(mlae_pkg::in_t beat);
    logic [31:0] sext_imm;
    logic [31:0] zext_imm;
    logic [4:0] sh;
    mlae_pkg::out_t r;
    sext_imm = {{16{beat.immediate[15]}}, beat.immediate};
    zext_imm = {16'b0, beat.immediate};
    sh = beat.immediate[4:0];
    r = '0;
    case (mlae_pkg::op_e'(beat.op))
      mlae_pkg::OP_ADD:   r = add_with_overflow(beat.rs_value, beat.rt_value);
      mlae_pkg::OP_ADDU:  r.result = beat.rs_value + beat.rt_value;
      mlae_pkg::OP_SUB:   r = add_with_overflow(beat.rs_value, ~beat.rt_value + 32'd1);
      mlae_pkg::OP_AND:   r.result = beat.rs_value & beat.rt_value;
      mlae_pkg::OP_OR:    r.result = beat.rs_value | beat.rt_value;
      mlae_pkg::OP_XOR:   r.result = beat.rs_value ^ beat.rt_value;
      mlae_pkg::OP_NOR:   r.result = ~(beat.rs_value | beat.rt_value);
      mlae_pkg::OP_NAND:  r.result = ~(beat.rs_value & beat.rt_value);
      mlae_pkg::OP_SLT:   r.result = signed_less(beat.rs_value, beat.rt_value);
      mlae_pkg::OP_SLL:   r.result = beat.rt_value << sh;
      mlae_pkg::OP_SRL:   r.result = beat.rt_value >> sh;
      mlae_pkg::OP_SRA:   r.result = $signed(beat.rt_value) >>> sh;
      mlae_pkg::OP_ADDI:  r = add_with_overflow(beat.rs_value, sext_imm);
      mlae_pkg::OP_ADDIU: r.result = beat.rs_value + sext_imm;
      mlae_pkg::OP_MEMA:  r = add_with_overflow(beat.rs_value, sext_imm);
      mlae_pkg::OP_LUI:   r.result = {beat.immediate, 16'b0};
      mlae_pkg::OP_ANDI:  r.result = beat.rs_value & zext_imm;
      mlae_pkg::OP_ORI:   r.result = beat.rs_value | zext_imm;
      mlae_pkg::OP_NORI:  r.result = ~(beat.rs_value | zext_imm);
      mlae_pkg::OP_SLTI:  r.result = signed_less(beat.rs_value, sext_imm);
      default:            r = '0;
    endcase
    return r;
  endfunction

  function automatic logic idling_allowed();
    return (pending_beats.size() > QuietTail) && (((beats_sent / 128) % 4) != 3);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(5, 0))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h7fff_ffff;
      3: return 32'h8000_0000;
      4: return $urandom_range(40, 0);
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_beat(logic [4:0] op, logic [31:0] rs, logic [31:0] rt,
                            logic [15:0] imm);
    mlae_pkg::in_t beat;
    beat.op = op;
    beat.rs_value = rs;
    beat.rt_value = rt;
    beat.immediate = imm;
    pending_beats.push_back(beat);
  endtask

  task automatic flag_mismatch(string why, mlae_pkg::out_t want, mlae_pkg::out_t got);
    mismatch_count++;
    if (mismatch_count <= MaxShown) begin
      $display("%0t: %s: expected result %h overflow %b, got result %h overflow %b",
               $realtime, why, want.result, want.overflow, got.result, got.overflow);
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(alu_predict(in_data_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0) begin
          send_gap   <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (idling_allowed() && $urandom_range(7, 0) == 0) begin
          send_gap   <= $urandom_range(12, 0);
          in_valid_i <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          in_data_i  <= pending_beats.pop_front();
          in_valid_i <= 1'b1;
          beats_sent <= beats_sent + 1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_gap   <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("result beat with none expected", '0, out_data_o);
        end else begin
          mlae_pkg::out_t want;
          want = expected_results.pop_front();
          if (out_data_o.result !== want.result) begin
            flag_mismatch("result field", want, out_data_o);
          end
          if (out_data_o.overflow !== want.overflow) begin
            flag_mismatch("overflow field", want, out_data_o);
          end
        end
      end
      if (stall_gap != 0) begin
        stall_gap   <= stall_gap - 1;
        out_stall_i <= 1'b1;
      end else if (idling_allowed() && $urandom_range(7, 0) == 0) begin
        stall_gap   <= $urandom_range(12, 0);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    logic [4:0] op;
    logic [15:0] imm;
    // signed overflow edges, including the negated most negative rt on sub, then logic and slt corner values
    queue_beat(mlae_pkg::OP_ADD, 32'h7fff_ffff, 32'h0000_0001, 16'h0000);
    queue_beat(mlae_pkg::OP_ADD, 32'h8000_0000, 32'h8000_0000, 16'hffff);
    queue_beat(mlae_pkg::OP_ADD, 32'hffff_ffff, 32'h0000_0001, 16'h0000);
    queue_beat(mlae_pkg::OP_ADDU, 32'hffff_ffff, 32'hffff_ffff, 16'h0000);
    queue_beat(mlae_pkg::OP_SUB, 32'h0000_0000, 32'h8000_0000, 16'h0000);
    queue_beat(mlae_pkg::OP_SUB, 32'hffff_ffff, 32'h8000_0000, 16'h0000);
    queue_beat(mlae_pkg::OP_SUB, 32'h8000_0000, 32'h0000_0001, 16'h0000);
    queue_beat(mlae_pkg::OP_AND, 32'hffff_ffff, 32'ha5a5_5a5a, 16'h0000);
    queue_beat(mlae_pkg::OP_OR, 32'h0000_0000, 32'h8000_0001, 16'h0000);
    queue_beat(mlae_pkg::OP_XOR, 32'hffff_ffff, 32'h0f0f_0f0f, 16'h0000);
    queue_beat(mlae_pkg::OP_NOR, 32'h0000_0000, 32'h0000_0000, 16'h0000);
    queue_beat(mlae_pkg::OP_NAND, 32'hffff_ffff, 32'hffff_ffff, 16'h0000);
    queue_beat(mlae_pkg::OP_SLT, 32'h8000_0000, 32'h7fff_ffff, 16'h0000);
    queue_beat(mlae_pkg::OP_SLT, 32'h7fff_ffff, 32'h7fff_ffff, 16'h0000);
    // shift amount taken from the low five bits only, then immediate forms and undefined opcodes
    queue_beat(mlae_pkg::OP_SLL, 32'h0000_0000, 32'hffff_ffff, 16'hffff);
    queue_beat(mlae_pkg::OP_SRL, 32'h0000_0000, 32'h8000_0000, 16'hffe0);
    queue_beat(mlae_pkg::OP_SRA, 32'h0000_0000, 32'h8000_0000, 16'h001f);
    queue_beat(mlae_pkg::OP_ADDI, 32'h7fff_ffff, 32'h0000_0000, 16'h0001);
    queue_beat(mlae_pkg::OP_ADDI, 32'h8000_0000, 32'h0000_0000, 16'hffff);
    queue_beat(mlae_pkg::OP_ADDIU, 32'h0000_0000, 32'h0000_0000, 16'h8000);
    queue_beat(mlae_pkg::OP_MEMA, 32'h7fff_8000, 32'h0000_0000, 16'h7fff);
    queue_beat(mlae_pkg::OP_LUI, 32'h0000_0000, 32'h0000_0000, 16'hffff);
    queue_beat(mlae_pkg::OP_ANDI, 32'hffff_ffff, 32'h0000_0000, 16'hffff);
    queue_beat(mlae_pkg::OP_ORI, 32'h8000_0000, 32'h0000_0000, 16'h8001);
    queue_beat(mlae_pkg::OP_NORI, 32'hffff_0000, 32'h0000_0000, 16'hffff);
    queue_beat(mlae_pkg::OP_SLTI, 32'hffff_0000, 32'h0000_0000, 16'hffff);
    queue_beat(OpNone, 32'hffff_ffff, 32'hffff_ffff, 16'hffff);
    queue_beat(OpTop, 32'hffff_ffff, 32'hffff_ffff, 16'hffff);
    for (int i = 0; i < RandBeats; i++) begin
      if ($urandom_range(9, 0) == 0) begin
        op = 5'($urandom_range(OpTop, OpNone));
      end else begin
        op = 5'($urandom_range(mlae_pkg::OP_SLTI, mlae_pkg::OP_ADD));
      end
      case ($urandom_range(3, 0))
        0: imm = 16'(32'h8000 | $urandom_range(15, 0));
        1: imm = 16'($urandom_range(31, 0));
        default: imm = 16'($urandom);
      endcase
      queue_beat(op, pick_word(), pick_word(), imm);
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_beats.size() == 0 && !in_valid_i);
    wait (expected_results.size() == 0);
    repeat (8) @(posedge clk_i);
    while (expected_results.size() != 0) begin
      flag_mismatch("result beat never arrived", expected_results.pop_front(), '0);
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
